// File: rtl/btnp_pkg.sv
// Shared types and constants for the branch tree node pool.
// Holds the node word layout, memory request bundle, status codes and FSM states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package btnp_pkg;

   localparam int POOL_SIZE = 1024;
   localparam int IDX_W     = $clog2(POOL_SIZE);
   localparam int LINK_W    = IDX_W + 1;
   localparam int DEPTH_W   = 10;
   localparam int CNT_W     = 2;
   localparam int REC_W     = 11;
   localparam int TOTAL_W   = 32;

   localparam logic [LINK_W-1:0]  NODE_NONE = LINK_W'(POOL_SIZE);
   localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_INACTIVE = 2'd2,
      ST_RULE     = 2'd3
   } status_type;

   typedef enum logic {
      ACT_ADD   = 1'b0,
      ACT_CLOSE = 1'b1
   } action_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOKUP,
      S_FREE_LINK,
      S_WRITE_PARENT,
      S_WALK,
      S_DONE
   } state_type;

   // One entry of the node memory.
   typedef struct packed {
      logic               active;
      logic [CNT_W-1:0]   count;
      logic [DEPTH_W-1:0] depth;
      logic [LINK_W-1:0]  link;
   } node_word_type;

   localparam node_word_type ROOT_WORD = '{
      active: 1'b1, count: '0, depth: '0, link: NODE_NONE};

   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      node_word_type    wr_data;
   } mem_req_type;

endpackage

`default_nettype wire

// File: rtl/btnp_store.sv
// Node memory of the branch tree node pool: one read and one write port.
// Entries at or above the high-water mark read as free; the root reads as its
// reset value until first written. Depends on btnp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module btnp_store
   import btnp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire mem_req_type         mem_req,
   input  wire logic [LINK_W-1:0]   high_water,
   output node_word_type            rd_word
);

   node_word_type mem [POOL_SIZE];
   node_word_type q_ff;
   logic          rd_ok_ff;
   logic          rd_ok_in;
   logic          rd_root_ff;
   logic          rd_root_in;
   logic          root_init_ff;
   logic          root_init_in;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         q_ff <= mem[mem_req.rd_addr];
      end
   end

   always_comb begin
      rd_ok_in     = ({1'b0, mem_req.rd_addr} < high_water);
      rd_root_in   = (mem_req.rd_addr == '0) && root_init_ff;
      root_init_in = root_init_ff && !(mem_req.wr_en && (mem_req.wr_addr == '0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_init_ff <= 1'b1;
         rd_ok_ff     <= 1'b0;
         rd_root_ff   <= 1'b0;
      end else begin
         root_init_ff <= root_init_in;
         if (mem_req.rd_en) begin
            rd_ok_ff   <= rd_ok_in;
            rd_root_ff <= rd_root_in;
         end
      end
   end

   always_comb begin
      if (rd_root_ff) begin
         rd_word = ROOT_WORD;
      end else if (rd_ok_ff) begin
         rd_word = q_ff;
      end else begin
         rd_word = '0;
      end
   end

endmodule

`default_nettype wire

// File: rtl/btnp_ctrl.sv
// Sequencer of the branch tree node pool: allocation, reclaim walk, pool
// registers and the result register. Depends on btnp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module btnp_ctrl
   import btnp_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_action,
   input  wire logic [IDX_W-1:0]     req_node,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [1:0]                rsp_status,
   output logic [IDX_W-1:0]          rsp_new_node,
   output logic [DEPTH_W-1:0]        rsp_new_depth,
   output logic [REC_W-1:0]          rsp_reclaimed,
   output logic [TOTAL_W-1:0]        rsp_closed_total,
   output mem_req_type               mem_req,
   output logic [LINK_W-1:0]         high_water,
   input  wire node_word_type        rd_word
);

   state_type            state_ff, state_in;
   action_type           act_ff, act_in;
   logic [IDX_W-1:0]     node_ff, node_in;
   logic [IDX_W-1:0]     cur_ff, cur_in;
   node_word_type        par_ff, par_in;
   logic [LINK_W-1:0]    free_head_ff, free_head_in;
   logic [LINK_W-1:0]    hw_ff, hw_in;
   logic [TOTAL_W-1:0]   freed_ff, freed_in;
   logic [REC_W-1:0]     rec_ff, rec_in;
   status_type           res_status_ff, res_status_in;
   logic [IDX_W-1:0]     res_node_ff, res_node_in;
   logic [DEPTH_W-1:0]   res_depth_ff, res_depth_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]     rsp_node_ff, rsp_node_in;
   logic [DEPTH_W-1:0]   rsp_depth_ff, rsp_depth_in;
   logic [REC_W-1:0]     rsp_rec_ff, rsp_rec_in;
   logic [TOTAL_W-1:0]   rsp_total_ff, rsp_total_in;

   function automatic logic [DEPTH_W-1:0] sat_inc(input logic [DEPTH_W-1:0] d);
      return (d == DEPTH_MAX) ? DEPTH_MAX : d + DEPTH_W'(1);
   endfunction

   always_comb begin
      logic [CNT_W-1:0]   cnt_adj;
      logic [REC_W-1:0]   rec_next;
      logic [DEPTH_W-1:0] depth_new;
      logic               do_step;
      logic               in_pool;
      node_word_type      new_word;

      state_in      = state_ff;
      act_in        = act_ff;
      node_in       = node_ff;
      cur_in        = cur_ff;
      par_in        = par_ff;
      free_head_in  = free_head_ff;
      hw_in         = hw_ff;
      freed_in      = freed_ff;
      rec_in        = rec_ff;
      res_status_in = res_status_ff;
      res_node_in   = res_node_ff;
      res_depth_in  = res_depth_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_node_in   = rsp_node_ff;
      rsp_depth_in  = rsp_depth_ff;
      rsp_rec_in    = rsp_rec_ff;
      rsp_total_in  = rsp_total_ff;
      mem_req       = '0;
      do_step       = 1'b0;

      // A parent one step up the walk loses the child that was just freed.
      cnt_adj  = ((state_ff == S_WALK) && (rd_word.count != '0)) ?
                 rd_word.count - CNT_W'(1) : rd_word.count;
      rec_next = rec_ff + REC_W'(1);
      in_pool  = ({1'b0, node_ff} < NODE_NONE);
      depth_new = sat_inc((state_ff == S_LOOKUP) ? rd_word.depth : par_ff.depth);
      new_word = '{active: 1'b1, count: '0, depth: depth_new, link: {1'b0, node_ff}};

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               act_in          = action_type'(req_action);
               node_in         = req_node;
               cur_in          = req_node;
               rec_in          = '0;
               res_node_in     = '0;
               res_depth_in    = '0;
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = req_node;
               state_in        = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            par_in = rd_word;
            if (!(rd_word.active && in_pool)) begin
               res_status_in = ST_INACTIVE;
               state_in      = S_DONE;
            end else if (act_ff == ACT_ADD) begin
               if (rd_word.count > CNT_W'(1)) begin
                  res_status_in = ST_RULE;
                  state_in      = S_DONE;
               end else if (free_head_ff != NODE_NONE) begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = free_head_ff[IDX_W-1:0];
                  res_node_in     = free_head_ff[IDX_W-1:0];
                  state_in        = S_FREE_LINK;
               end else if (hw_ff < NODE_NONE) begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = hw_ff[IDX_W-1:0];
                  mem_req.wr_data = new_word;
                  res_node_in     = hw_ff[IDX_W-1:0];
                  res_depth_in    = depth_new;
                  hw_in           = hw_ff + LINK_W'(1);
                  state_in        = S_WRITE_PARENT;
               end else begin
                  res_status_in = ST_FULL;
                  state_in      = S_DONE;
               end
            end else begin
               if (rd_word.count == CNT_W'(2)) begin
                  res_status_in = ST_OK;
                  state_in      = S_DONE;
               end else if (rd_word.count != '0) begin
                  res_status_in = ST_RULE;
                  state_in      = S_DONE;
               end else begin
                  do_step = 1'b1;
               end
            end
         end
         S_FREE_LINK: begin
            free_head_in    = (rd_word.link > NODE_NONE) ? NODE_NONE : rd_word.link;
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = res_node_ff;
            mem_req.wr_data = new_word;
            res_depth_in    = depth_new;
            state_in        = S_WRITE_PARENT;
         end
         S_WRITE_PARENT: begin
            mem_req.wr_en         = 1'b1;
            mem_req.wr_addr       = node_ff;
            mem_req.wr_data       = par_ff;
            mem_req.wr_data.count = par_ff.count + CNT_W'(1);
            res_status_in         = ST_OK;
            state_in              = S_DONE;
         end
         S_WALK: begin
            do_step = 1'b1;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_node_in   = res_node_ff;
               rsp_depth_in  = res_depth_ff;
               rsp_rec_in    = rec_ff;
               rsp_total_in  = freed_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // One node of the reclaim walk per cycle: the read of the next parent
      // is issued while the current node is written back.
      if (do_step) begin
         mem_req.wr_en   = 1'b1;
         mem_req.wr_addr = cur_ff;
         res_status_in   = ST_OK;
         if (cnt_adj != '0) begin
            mem_req.wr_data       = rd_word;
            mem_req.wr_data.count = cnt_adj;
            state_in              = S_DONE;
         end else begin
            mem_req.wr_data = '{active: 1'b0, count: '0, depth: '0, link: free_head_ff};
            free_head_in    = {1'b0, cur_ff};
            freed_in        = freed_ff + TOTAL_W'(1);
            rec_in          = rec_next;
            if ((rd_word.link >= NODE_NONE) || (rec_next == REC_W'(POOL_SIZE))) begin
               state_in = S_DONE;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = rd_word.link[IDX_W-1:0];
               cur_in          = rd_word.link[IDX_W-1:0];
               state_in        = S_WALK;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         free_head_ff <= NODE_NONE;
         hw_ff        <= LINK_W'(1);
         freed_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_head_ff <= free_head_in;
         hw_ff        <= hw_in;
         freed_ff     <= freed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      node_ff       <= node_in;
      cur_ff        <= cur_in;
      par_ff        <= par_in;
      rec_ff        <= rec_in;
      res_status_ff <= res_status_in;
      res_node_ff   <= res_node_in;
      res_depth_ff  <= res_depth_in;
      rsp_status_ff <= rsp_status_in;
      rsp_node_ff   <= rsp_node_in;
      rsp_depth_ff  <= rsp_depth_in;
      rsp_rec_ff    <= rsp_rec_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_new_node     = rsp_node_ff;
   assign rsp_new_depth    = rsp_depth_ff;
   assign rsp_reclaimed    = rsp_rec_ff;
   assign rsp_closed_total = rsp_total_ff;
   assign high_water       = hw_ff;

endmodule

`default_nettype wire

// File: rtl/branch_tree_node_pool.sv
// Top level of the branch tree node pool: sequencer plus node memory.
// Depends on btnp_pkg, btnp_ctrl and btnp_store.
`timescale 1ns / 1ps
`default_nettype none

// The block keeps a pool of 1024 binary tree nodes with node 0 as the active
// root after reset. An add transaction (action 0) allocates a child under the
// given parent, reusing the most recently freed node first and otherwise the
// next never-used index; a close transaction (action 1) frees the node and
// then each ancestor left without open children, returning how many nodes
// were freed. Every request transaction produces exactly one response
// transaction, and errors leave the pool untouched. All per-node state lives
// in one memory with one read and one write port, so the block handles one
// transaction at a time. An add reads the parent, then, when it reuses a
// freed node, reads that node's link, and writes the new node and then the
// parent. A close on a node with two children succeeds and frees nothing;
// otherwise its walk frees one node per step up to the root or to the first
// ancestor that keeps an open child. The result register is loaded only once
// the previous response in it is no longer held by rsp_stall. The next
// request is accepted the cycle after the result is registered, even while
// that response still waits on rsp_stall.
// No clearing pass is needed after reset: indices at or above the high-water
// mark read as free and the root reads as its reset value until first written.
module branch_tree_node_pool
   import btnp_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_action,
   input  wire logic [IDX_W-1:0]     req_node,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [1:0]                rsp_status,
   output logic [IDX_W-1:0]          rsp_new_node,
   output logic [DEPTH_W-1:0]        rsp_new_depth,
   output logic [REC_W-1:0]          rsp_reclaimed,
   output logic [TOTAL_W-1:0]        rsp_closed_total
);

   // Memory request from the sequencer and the word read back in the cycle after it.
   mem_req_type          mem_req;
   node_word_type        rd_word;
   logic [LINK_W-1:0]    high_water;

   btnp_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_node         (req_node),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_new_node     (rsp_new_node),
      .rsp_new_depth    (rsp_new_depth),
      .rsp_reclaimed    (rsp_reclaimed),
      .rsp_closed_total (rsp_closed_total),
      .mem_req          (mem_req),
      .high_water       (high_water),
      .rd_word          (rd_word)
   );

   // Indices at or above the high-water mark have never been allocated.
   btnp_store u_store (
      .clock      (clock),
      .reset      (reset),
      .mem_req    (mem_req),
      .high_water (high_water),
      .rd_word    (rd_word)
   );

endmodule

`default_nettype wire

// File: rtl/btnp_checker.sv
// Port-level checks for the branch tree node pool, bound to the top level.
// Depends on btnp_pkg and branch_tree_node_pool.
`timescale 1ns / 1ps
`default_nettype none

module btnp_checker
   import btnp_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_stall,
   input wire logic                 req_action,
   input wire logic [IDX_W-1:0]     req_node,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_stall,
   input wire logic [1:0]           rsp_status,
   input wire logic [IDX_W-1:0]     rsp_new_node,
   input wire logic [DEPTH_W-1:0]   rsp_new_depth,
   input wire logic [REC_W-1:0]     rsp_reclaimed,
   input wire logic [TOTAL_W-1:0]   rsp_closed_total
);

   // Reset empties the response register.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A failed transaction reports no node, no depth and nothing freed.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |->
      ((rsp_new_node == '0) && (rsp_new_depth == '0) && (rsp_reclaimed == '0)))
      else $error("error response carries data");

   // An allocation never hands out the root and frees nothing.
   a_alloc_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_new_depth != '0)) |->
      ((rsp_new_node != '0) && (rsp_reclaimed == '0) && (rsp_status == ST_OK)))
      else $error("allocation response malformed");

   // A stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
      (rsp_valid && $stable(rsp_status) && $stable(rsp_new_node) &&
       $stable(rsp_new_depth) && $stable(rsp_reclaimed) && $stable(rsp_closed_total)))
      else $error("stalled response changed");

endmodule

bind branch_tree_node_pool btnp_checker u_btnp_checker (.*);

`default_nettype wire
